// ===== sv/twdd_pkg.sv =====
// ----------------------------------------------------------------------------
// twdd_pkg
// Shared types, constants and codes for the time window dedup table.
// ----------------------------------------------------------------------------
package twdd_pkg;

  localparam int CAPACITY   = 1024;
  localparam int ADDR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int ENTRY_W    = 11;
  localparam int DATA_W     = 64;
  localparam int CFG_ADDR_W = 4;

  localparam logic [DATA_W-1:0] WINDOW_RESET = 64'd5000000000;

  localparam logic OP_CHECK = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic REG_WINDOW = 1'b0;

  typedef struct packed {
    logic              operation;
    logic [DATA_W-1:0] fingerprint_key;
    logic [DATA_W-1:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic               is_duplicate;
    logic [DATA_W-1:0]  check_count;
    logic [DATA_W-1:0]  duplicate_count;
    logic [ENTRY_W-1:0] entry_count;
  } out_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] stamp;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic latch;
    logic scan_en;
    logic commit;
    logic clear_stats;
  } twdd_cmd_t;

  typedef struct packed {
    logic op_clear;
    logic empty;
    logic scan_last;
    logic pipe_busy;
  } twdd_sts_t;

endpackage

// ===== sv/twdd_ctrl.sv =====
// ----------------------------------------------------------------------------
// twdd_ctrl
// Sequencer: accepts an item, scans the ring and commits; a clear skips both.
// ----------------------------------------------------------------------------
module twdd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  twdd_pkg::twdd_sts_t sts,
  output twdd_pkg::twdd_cmd_t cmd,
  output logic               busy
);
  import twdd_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        priority if (sts.op_clear) begin
          cmd.clear_stats = 1'b1;
          state_nxt       = ST_IDLE;
        end else if (sts.empty) begin
          state_nxt = ST_UPDATE;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/twdd_dpath.sv =====
// ----------------------------------------------------------------------------
// twdd_dpath
// Ring memory, scan pipeline, match logic, counters and result register.
// ----------------------------------------------------------------------------
module twdd_dpath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  twdd_pkg::twdd_cmd_t  cmd,
  input  twdd_pkg::in_item_t   in_item,
  input  logic [63:0]          window,
  output twdd_pkg::twdd_sts_t  sts,
  output logic                 out_valid,
  output twdd_pkg::out_item_t  out_item
);
  import twdd_pkg::*;

  entry_t            mem [CAPACITY];

  in_item_t          req_r;
  entry_t            rdata_r;
  logic              keyeq_r;
  logic [DATA_W-1:0] age_r;

  logic              v1_r, v1_nxt;
  logic              v2_r, v2_nxt;
  logic              hit_r, hit_nxt;
  logic [ADDR_W-1:0] scan_addr_r, scan_addr_nxt;
  logic [ADDR_W-1:0] wpos_r, wpos_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [DATA_W-1:0] checked_r, checked_nxt;
  logic [DATA_W-1:0] dup_r, dup_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  // memory: one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.commit && !hit_r) begin
      mem[wpos_r] <= '{key: req_r.fingerprint_key, stamp: req_r.now_time};
    end
    if (cmd.scan_en) begin
      rdata_r <= mem[scan_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r <= in_item;
    end
    keyeq_r    <= (rdata_r.key == req_r.fingerprint_key);
    age_r      <= req_r.now_time - rdata_r.stamp;
    out_item_r <= out_item_nxt;
  end

  always_comb begin
    v1_nxt        = cmd.scan_en;
    v2_nxt        = v1_r;
    hit_nxt       = hit_r;
    scan_addr_nxt = scan_addr_r;
    wpos_nxt      = wpos_r;
    count_nxt     = count_r;
    checked_nxt   = checked_r;
    dup_nxt       = dup_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;

    if (cmd.latch) begin
      hit_nxt       = 1'b0;
      scan_addr_nxt = '0;
    end
    if (cmd.scan_en) begin
      scan_addr_nxt = scan_addr_r + ADDR_W'(1);
    end
    if (v2_r && keyeq_r && (age_r < window)) begin
      hit_nxt = 1'b1;
    end

    if (cmd.clear_stats) begin
      checked_nxt   = '0;
      dup_nxt       = '0;
      out_valid_nxt = 1'b1;
    end
    if (cmd.commit) begin
      checked_nxt   = checked_r + DATA_W'(1);
      out_valid_nxt = 1'b1;
      if (hit_r) begin
        dup_nxt = dup_r + DATA_W'(1);
      end else begin
        wpos_nxt = (wpos_r == ADDR_W'(CAPACITY - 1)) ? '0 : wpos_r + ADDR_W'(1);
        if (count_r != CNT_W'(CAPACITY)) begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
    end
    if (cmd.clear_stats || cmd.commit) begin
      out_item_nxt.is_duplicate    = cmd.commit & hit_r;
      out_item_nxt.check_count     = checked_nxt;
      out_item_nxt.duplicate_count = dup_nxt;
      out_item_nxt.entry_count     = ENTRY_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      hit_r       <= 1'b0;
      scan_addr_r <= '0;
      wpos_r      <= '0;
      count_r     <= '0;
      checked_r   <= '0;
      dup_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      hit_r       <= hit_nxt;
      scan_addr_r <= scan_addr_nxt;
      wpos_r      <= wpos_nxt;
      count_r     <= count_nxt;
      checked_r   <= checked_nxt;
      dup_r       <= dup_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign sts.op_clear  = (req_r.operation == OP_CLEAR);
  assign sts.empty     = (count_r == '0);
  assign sts.scan_last = ((CNT_W'(scan_addr_r) + CNT_W'(1)) == count_r);
  assign sts.pipe_busy = v1_r | v2_r;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== sv/time_window_dedup_table.sv =====
// ----------------------------------------------------------------------------
// time_window_dedup_table
// Sliding time window duplicate filter over a ring of 1024 fingerprints.
// ----------------------------------------------------------------------------
// A check item is decoded in the decide state, the ring is scanned one entry
// per cycle through the single read port of the ring memory, the compare
// pipeline drains, the update state commits and the result is registered;
// an empty ring skips scan and drain. A clear item goes from the decide
// state straight to its result. busy stays high from the accept until the
// result; out_valid marks the result for one cycle and must be taken then.
// The window register sits at address 0 of the APB port; the user must
// write it only while busy is low, as the block does not enforce this.
module time_window_dedup_table (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       start,
  output logic                                       busy,
  input  twdd_pkg::in_item_t                         in_item,
  output logic                                       out_valid,
  output twdd_pkg::out_item_t                        out_item,
  input  logic                                       psel,
  input  logic                                       penable,
  input  logic                                       pwrite,
  input  logic [twdd_pkg::CFG_ADDR_W-1:0]            paddr,
  input  logic [twdd_pkg::DATA_W-1:0]                pwdata,
  output logic [twdd_pkg::DATA_W-1:0]                prdata,
  output logic                                       pready
);
  import twdd_pkg::*;

  twdd_cmd_t         cmd;
  twdd_sts_t         sts;
  logic [DATA_W-1:0] window_r, window_nxt;
  logic              reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[CFG_ADDR_W-1] == REG_WINDOW);
  assign prdata  = reg_sel ? window_r : '0;

  always_comb begin
    window_nxt = window_r;
    if (psel && penable && pwrite && pready && reg_sel) begin
      window_nxt = pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
    end else begin
      window_r <= window_nxt;
    end
  end

  twdd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  twdd_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .window    (window_r),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

`ifndef SYNTH
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(rst_n)) |-> $past(busy))
    else $error("result without an item in progress");
`endif

endmodule

// ===== tb/sv/time_window_dedup_table_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_window_dedup_table_checker
// Watches the item, result and APB channels of the dedup table, keeps a
// shadow ring of fingerprints and stamps, predicts each verdict and counter
// snapshot on accept, and compares every result field against it in order.
// ----------------------------------------------------------------------------
module time_window_dedup_table_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            busy,
  input  twdd_pkg::in_item_t              in_item,
  input  logic                            out_valid,
  input  twdd_pkg::out_item_t             out_item,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [twdd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [twdd_pkg::DATA_W-1:0]     pwdata,
  input  logic                            pready,
  output int                              mismatches,
  output int                              outstanding
);
  import twdd_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] WINDOW_ADDR = CFG_ADDR_W'(8 * REG_WINDOW);

  logic [DATA_W-1:0] ring_keys   [CAPACITY];
  logic [DATA_W-1:0] ring_stamps [CAPACITY];
  int                ring_head;
  int                ring_fill;
  logic [DATA_W-1:0] checks_seen;
  logic [DATA_W-1:0] dups_seen;
  logic [DATA_W-1:0] window_len;
  out_item_t         verdict_q [$];
  int                errors;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    errors      = 0;
  end

  function automatic out_item_t filter_item(input in_item_t it);
    out_item_t         res;
    logic              hit;
    logic [DATA_W-1:0] age;
    hit = 1'b0;
    if (it.operation == OP_CLEAR) begin
      checks_seen = '0;
      dups_seen   = '0;
    end else begin
      checks_seen = checks_seen + 1'b1;
      for (int i = 0; i < ring_fill; i++) begin
        age = it.now_time - ring_stamps[i];
        if (ring_keys[i] == it.fingerprint_key && age < window_len) hit = 1'b1;
      end
      if (hit) begin
        dups_seen = dups_seen + 1'b1;
      end else begin
        ring_keys[ring_head]   = it.fingerprint_key;
        ring_stamps[ring_head] = it.now_time;
        ring_head              = (ring_head + 1) % CAPACITY;
        if (ring_fill < CAPACITY) ring_fill++;
      end
    end
    res.is_duplicate    = hit;
    res.check_count     = checks_seen;
    res.duplicate_count = dups_seen;
    res.entry_count     = ENTRY_W'(ring_fill);
    return res;
  endfunction

  function automatic bit field_ok(input string name, input logic [DATA_W-1:0] want,
                                  input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t %s expected %h actual %h", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    bit        good;
    if (!rst_n) begin
      ring_head   = 0;
      ring_fill   = 0;
      checks_seen = '0;
      dups_seen   = '0;
      window_len  = WINDOW_RESET;
      verdict_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == WINDOW_ADDR) window_len = pwdata;
      if (out_valid) begin
        if (verdict_q.size() == 0) begin
          $display("%0t result with no item waiting: %h", $time, out_item);
          errors++;
        end else begin
          want = verdict_q.pop_front();
          good = field_ok("is_duplicate", want.is_duplicate, out_item.is_duplicate);
          good = field_ok("check_count", want.check_count, out_item.check_count) && good;
          good = field_ok("duplicate_count", want.duplicate_count,
                          out_item.duplicate_count) && good;
          good = field_ok("entry_count", want.entry_count, out_item.entry_count) && good;
          if (!good) errors++;
        end
      end
      if (start && !busy) verdict_q.push_back(filter_item(in_item));
    end
    mismatches  <= errors;
    outstanding <= verdict_q.size();
  end

endmodule

// ===== tb/sv/time_window_dedup_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_window_dedup_table_tb
// Drives directed and random check and clear items into the dedup table,
// moves the window register through zero, its reset value, its maximum and
// random settings, and judges by the checker's mismatch and outstanding counts.
// ----------------------------------------------------------------------------
module time_window_dedup_table_tb;
  import twdd_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] WINDOW_ADDR = CFG_ADDR_W'(8 * REG_WINDOW);
  localparam logic [DATA_W-1:0]     ALL_ONES    = '1;
  localparam logic [DATA_W-1:0]     ALT_A       = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam logic [DATA_W-1:0]     ALT_5       = 64'h5555_5555_5555_5555;

  logic                  clk     = 1'b0;
  logic                  rst_n   = 1'b0;
  logic                  start   = 1'b0;
  in_item_t              in_item = '0;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0]     pwdata  = '0;
  logic                  busy;
  logic                  out_valid;
  out_item_t             out_item;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;
  int                    mismatches;
  int                    outstanding;

  int unsigned           idle_pct;
  int unsigned           stride;
  logic [DATA_W-1:0]     now_ts;
  logic [DATA_W-1:0]     key_pool [8];

  time_window_dedup_table DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  time_window_dedup_table_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_item    (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #30_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic in_item_t mk(input logic op, input logic [DATA_W-1:0] key,
                                  input logic [DATA_W-1:0] stamp);
    in_item_t it;
    it.operation       = op;
    it.fingerprint_key = key;
    it.now_time        = stamp;
    return it;
  endfunction

  task automatic send(input in_item_t it);
    in_item <= it;
    do begin
      start <= ($urandom_range(99) >= idle_pct);
      @(posedge clk);
    end while (!(start && !busy));
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (busy || outstanding != 0) @(posedge clk);
  endtask

  task automatic write_window(input logic [DATA_W-1:0] value);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= WINDOW_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic next_item(output in_item_t it);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8) now_ts = now_ts - $urandom_range(stride);
    else if (pick < 12) now_ts = {$urandom, $urandom};
    else now_ts = now_ts + $urandom_range(stride);
    it.operation       = ($urandom_range(99) < 5) ? OP_CLEAR : OP_CHECK;
    it.fingerprint_key = ($urandom_range(99) < 75) ? key_pool[$urandom_range(7)]
                                                   : {$urandom, $urandom};
    it.now_time        = now_ts;
  endtask

  task automatic run_phase(input int unsigned pct, input logic [DATA_W-1:0] win,
                           input int unsigned span, input int count);
    in_item_t it;
    write_window(win);
    idle_pct = pct;
    stride   = span;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2 || $urandom_range(99) < 3) drain();
      next_item(it);
      send(it);
    end
  endtask

  initial begin
    idle_pct    = 0;
    stride      = 0;
    now_ts      = '0;
    key_pool[0] = '0;
    key_pool[1] = ALL_ONES;
    key_pool[2] = ALT_A;
    key_pool[3] = ALT_5;
    for (int i = 4; i < 8; i++) key_pool[i] = {$urandom, $urandom};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(mk(OP_CHECK, '0, '0));
    send(mk(OP_CHECK, '0, '0));
    send(mk(OP_CHECK, '0, WINDOW_RESET - 1));
    send(mk(OP_CHECK, '0, WINDOW_RESET));
    send(mk(OP_CHECK, ALL_ONES, ALL_ONES));
    send(mk(OP_CHECK, ALL_ONES, '0));
    send(mk(OP_CHECK, ALT_A, ALT_5));
    send(mk(OP_CHECK, ALT_5, ALT_A));
    send(mk(OP_CHECK, ALT_A, ALT_5 - 1));
    send(mk(OP_CLEAR, ALL_ONES, ALL_ONES));
    send(mk(OP_CHECK, '0, WINDOW_RESET + 10));
    write_window('0);
    send(mk(OP_CHECK, '0, WINDOW_RESET));
    send(mk(OP_CHECK, '0, WINDOW_RESET));
    write_window(ALL_ONES);
    send(mk(OP_CHECK, ALL_ONES, ALL_ONES - 1));
    send(mk(OP_CHECK, ALL_ONES, ALL_ONES));
    send(mk(OP_CHECK, ALT_5, '0));
    send(mk(OP_CLEAR, '0, '0));
    send(mk(OP_CLEAR, '0, '0));

    run_phase(7, 64'd1000, 700, 193);
    run_phase(77, ALL_ONES, 32'hFFFF_FFFF, 193);
    run_phase(0, {$urandom_range(3), $urandom}, 32'h8000_0000, 194);

    drain();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
